/* sv/slha_pkg.sv */
package slha_pkg;

    localparam int unsigned NUM_CLASSES  = 20;
    localparam int unsigned ROOT_BASE    = 12;
    localparam int unsigned LAYOUT_BYTES = 96;
    localparam int unsigned INIT_CHUNK   = 1 << 8;
    localparam int unsigned MIN_BLOCK    = 16;
    localparam int unsigned CHUNK_RESET  = 256;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_NO_MEM  = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef logic [17:0] byte_addr_t;
    typedef logic [31:0] heap_word_t;

    // Size field of a header or footer word, flag bits cleared.
    function automatic byte_addr_t size18(heap_word_t w);
        return {w[17:3], 3'b000};
    endfunction

    // Header or footer word: size with prev-allocated and allocated flags.
    function automatic heap_word_t hdr(byte_addr_t sz, logic pa, logic al);
        return {14'b0, sz[17:3], 1'b0, pa, al};
    endfunction

    // Size class of a block size in bytes.
    function automatic logic [4:0] size_class(heap_word_t s);
        logic [4:0]  c;
        heap_word_t  t;
        c = 5'd19;
        t = s - 32'd16;
        if (s <= 32'd96) begin
            c = (s < 32'd16) ? 5'd0 : t[7:3];
        end else begin
            for (int i = 0; i < 9; i++) begin
                if (s <= (32'd192 << i) && s > (32'd96 << i)) begin
                    c = 5'(11 + i);
                end
            end
        end
        return c;
    endfunction

    function automatic byte_addr_t root_of(logic [4:0] cls);
        return 18'(ROOT_BASE) + {11'b0, cls, 2'b00};
    endfunction

endpackage

/* sv/segregated_list_heap_allocator.sv */
// Segregated free-list heap allocator with first-fit search.
// Requests arrive on the s_ channel: s_tuser selects allocate (0) or free (1), s_tdata
// carries the payload size for an allocate and the payload offset for a free. Every
// request produces exactly one result on the m_ channel: a status and, for a successful
// allocate, the payload byte offset of the new block.
// cfg_we/cfg_wdata set the minimum number of bytes by which the heap grows when no free
// block fits; write it only while the block is idle.
// One request is handled at a time by a sequencer around a single-port heap memory,
// one read or one write per cycle. How long a free takes depends on how many neighbours
// are coalesced. An allocate takes longer for every size class searched and every
// free-list entry visited; growing the heap adds to it, and the very first allocate
// also lays the heap out. Every list and header access goes through the memory port.
// After reset the heap is empty and not laid out; there is no clearing pass, the first
// allocate writes every word it later reads. A finished result waits in an output
// register while the receiver stalls; the sequencer then holds in its final state and the
// next request is taken once the result register is free or being emptied.
module segregated_list_heap_allocator
    import slha_pkg::*;
#(
    parameter int unsigned HEAP_WORDS = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: req_size[15:0], block_offset[31:16].
    input  logic [31:0] s_tdata,
    // Fields from bit 0: req_type[0].
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: status[1:0], result_offset[17:2], zero padding[23:18].
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);

    localparam int unsigned AW          = $clog2(HEAP_WORDS);
    localparam int unsigned HEAP_BYTES  = HEAP_WORDS * 4;
    localparam int unsigned BUDGET_INIT = HEAP_WORDS / 4 + 1;
    localparam int unsigned BW          = $clog2(BUDGET_INIT + 1);

    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_L0     = 6'd1;
    localparam logic [5:0] ST_L1     = 6'd2;
    localparam logic [5:0] ST_L2     = 6'd3;
    localparam logic [5:0] ST_L3     = 6'd4;
    localparam logic [5:0] ST_L4     = 6'd5;
    localparam logic [5:0] ST_A0     = 6'd6;
    localparam logic [5:0] ST_A1     = 6'd7;
    localparam logic [5:0] ST_FROOT  = 6'd8;
    localparam logic [5:0] ST_FLDP   = 6'd9;
    localparam logic [5:0] ST_FCHK   = 6'd10;
    localparam logic [5:0] ST_FHD    = 6'd11;
    localparam logic [5:0] ST_NOFIT  = 6'd12;
    localparam logic [5:0] ST_GROWN  = 6'd13;
    localparam logic [5:0] ST_G0     = 6'd14;
    localparam logic [5:0] ST_G1     = 6'd15;
    localparam logic [5:0] ST_G2     = 6'd16;
    localparam logic [5:0] ST_G3     = 6'd17;
    localparam logic [5:0] ST_G4     = 6'd18;
    localparam logic [5:0] ST_G5     = 6'd19;
    localparam logic [5:0] ST_M0     = 6'd20;
    localparam logic [5:0] ST_M1     = 6'd21;
    localparam logic [5:0] ST_M2     = 6'd22;
    localparam logic [5:0] ST_MP1    = 6'd23;
    localparam logic [5:0] ST_MP2    = 6'd24;
    localparam logic [5:0] ST_MP3    = 6'd25;
    localparam logic [5:0] ST_MW0    = 6'd26;
    localparam logic [5:0] ST_MW1    = 6'd27;
    localparam logic [5:0] ST_MW2    = 6'd28;
    localparam logic [5:0] ST_MF0    = 6'd29;
    localparam logic [5:0] ST_MF1    = 6'd30;
    localparam logic [5:0] ST_R0     = 6'd31;
    localparam logic [5:0] ST_R1     = 6'd32;
    localparam logic [5:0] ST_R2     = 6'd33;
    localparam logic [5:0] ST_R3     = 6'd34;
    localparam logic [5:0] ST_R4     = 6'd35;
    localparam logic [5:0] ST_P0     = 6'd36;
    localparam logic [5:0] ST_P1     = 6'd37;
    localparam logic [5:0] ST_P2     = 6'd38;
    localparam logic [5:0] ST_P3     = 6'd39;
    localparam logic [5:0] ST_P4     = 6'd40;
    localparam logic [5:0] ST_P5     = 6'd41;
    localparam logic [5:0] ST_PL0    = 6'd42;
    localparam logic [5:0] ST_PL1    = 6'd43;
    localparam logic [5:0] ST_PL2    = 6'd44;
    localparam logic [5:0] ST_PL3    = 6'd45;
    localparam logic [5:0] ST_PS1    = 6'd46;
    localparam logic [5:0] ST_PS2    = 6'd47;
    localparam logic [5:0] ST_PS3    = 6'd48;
    localparam logic [5:0] ST_PS4    = 6'd49;
    localparam logic [5:0] ST_PN1    = 6'd50;
    localparam logic [5:0] ST_PN2    = 6'd51;
    localparam logic [5:0] ST_PDONE  = 6'd52;
    localparam logic [5:0] ST_F0     = 6'd53;
    localparam logic [5:0] ST_F1     = 6'd54;
    localparam logic [5:0] ST_F2     = 6'd55;
    localparam logic [5:0] ST_F3     = 6'd56;
    localparam logic [5:0] ST_F4     = 6'd57;
    localparam logic [5:0] ST_DONE   = 6'd58;

    // Sequencer state and the return points of its three subroutines: list
    // removal and push (leaf), coalescing, and heap growth.
    logic [5:0] st_reg, st_next;
    logic [5:0] ret_leaf_reg, ret_leaf_next;
    logic [5:0] ret_merge_reg, ret_merge_next;
    logic [5:0] ret_grow_reg, ret_grow_next;

    logic [15:0] rsize_reg, rsize_next;
    byte_addr_t  bp_reg, bp_next;
    byte_addr_t  asize_reg, asize_next;
    byte_addr_t  size_reg, size_next;
    byte_addr_t  nsize_reg, nsize_next;
    byte_addr_t  psize_reg, psize_next;
    byte_addr_t  pb_reg, pb_next;
    byte_addr_t  nb_reg, nb_next;
    logic        pa_reg, pa_next;
    logic        pfree_reg, pfree_next;
    logic        nfree_reg, nfree_next;
    byte_addr_t  arg_reg, arg_next;
    byte_addr_t  root_reg, root_next;
    byte_addr_t  lp_reg, lp_next;
    byte_addr_t  ls_reg, ls_next;
    byte_addr_t  p_reg, p_next;
    logic [4:0]  cls_reg, cls_next;
    logic [BW-1:0] budget_reg, budget_next;
    byte_addr_t  ext_reg, ext_next;
    logic        grow_ok_reg, grow_ok_next;
    byte_addr_t  csize_reg, csize_next;
    byte_addr_t  rem_reg, rem_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [15:0] res_off_reg, res_off_next;
    logic [16:0] heap_top_reg, heap_top_next;
    logic        heap_ready_reg, heap_ready_next;
    logic [16:0] chunk_reg, chunk_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [15:0] out_off_reg, out_off_next;

    // Heap memory: one address per cycle, registered read data. Words beyond the
    // heap read as zero and writes there are dropped.
    heap_word_t  heap_mem [HEAP_WORDS];
    heap_word_t  rd_raw_reg;
    logic        rd_ok_reg;
    byte_addr_t  mem_addr;
    logic        mem_we;
    heap_word_t  mem_wdata;
    logic [15:0] mem_word;
    logic        mem_in_range;
    heap_word_t  rdata;

    assign mem_word     = mem_addr[17:2];
    assign mem_in_range = mem_word < 16'(HEAP_WORDS);
    assign rdata        = rd_ok_reg ? rd_raw_reg : '0;

    always_ff @(posedge aclk) begin
        if (mem_we && mem_in_range) begin
            heap_mem[mem_word[AW-1:0]] <= mem_wdata;
        end
        rd_raw_reg <= heap_mem[mem_word[AW-1:0]];
        rd_ok_reg  <= mem_in_range;
    end

    // Free-request checks made on acceptance.
    logic [15:0] in_off;
    logic        free_ok;
    assign in_off  = s_tdata[31:16];
    assign free_ok = (in_off != 16'd0) && heap_ready_reg && (in_off[2:0] == 3'b000) &&
                     (in_off >= 16'(LAYOUT_BYTES)) && ({1'b0, in_off} < heap_top_reg);

    // Growth size, rounded to a whole number of double words, and room check.
    logic [18:0] grow_sz;
    logic        grow_fits;
    assign grow_sz   = {1'b0, ext_reg[17:2], 2'b00} + (ext_reg[2] ? 19'd4 : 19'd0);
    assign grow_fits = grow_sz <= (19'(HEAP_BYTES) - {2'b0, heap_top_reg});

    heap_word_t  rd_size32;
    byte_addr_t  rd_size;
    byte_addr_t  room;
    assign rd_size32 = {rdata[31:3], 3'b000};
    assign rd_size   = size18(rdata);
    assign room      = {1'b0, heap_top_reg} - bp_reg;

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_off_reg, out_status_reg};

    always_comb begin
        st_next         = st_reg;
        ret_leaf_next   = ret_leaf_reg;
        ret_merge_next  = ret_merge_reg;
        ret_grow_next   = ret_grow_reg;
        rsize_next      = rsize_reg;
        bp_next         = bp_reg;
        asize_next      = asize_reg;
        size_next       = size_reg;
        nsize_next      = nsize_reg;
        psize_next      = psize_reg;
        pb_next         = pb_reg;
        nb_next         = nb_reg;
        pa_next         = pa_reg;
        pfree_next      = pfree_reg;
        nfree_next      = nfree_reg;
        arg_next        = arg_reg;
        root_next       = root_reg;
        lp_next         = lp_reg;
        ls_next         = ls_reg;
        p_next          = p_reg;
        cls_next        = cls_reg;
        budget_next     = budget_reg;
        ext_next        = ext_reg;
        grow_ok_next    = grow_ok_reg;
        csize_next      = csize_reg;
        rem_next        = rem_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        heap_top_next   = heap_top_reg;
        heap_ready_next = heap_ready_reg;
        chunk_next      = cfg_we ? cfg_wdata : chunk_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_off_next    = out_off_reg;
        mem_addr        = '0;
        mem_we          = 1'b0;
        mem_wdata       = '0;

        unique case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rsize_next = s_tdata[15:0];
                    bp_next    = {2'b0, in_off};
                    if (s_tuser[0] == REQ_ALLOC) begin
                        st_next = heap_ready_reg ? ST_A0 : ST_L0;
                    end else if (free_ok) begin
                        st_next = ST_F0;
                    end else begin
                        res_status_next = STATUS_IGNORED;
                        res_off_next    = '0;
                        st_next         = ST_DONE;
                    end
                end
            end
            // Heap layout: padding, prologue, list roots, epilogue, first chunk.
            ST_L0: begin
                mem_addr = 18'd0;
                mem_we   = 1'b1;
                st_next  = ST_L1;
            end
            ST_L1: begin
                mem_addr  = 18'd4;
                mem_we    = 1'b1;
                mem_wdata = hdr(18'd8, 1'b0, 1'b1);
                st_next   = ST_L2;
            end
            ST_L2: begin
                mem_addr  = 18'd8;
                mem_we    = 1'b1;
                mem_wdata = hdr(18'd8, 1'b0, 1'b1);
                cls_next  = '0;
                st_next   = ST_L3;
            end
            ST_L3: begin
                mem_addr = root_of(cls_reg);
                mem_we   = 1'b1;
                cls_next = cls_reg + 5'd1;
                if (cls_reg == 5'(NUM_CLASSES - 1)) begin
                    st_next = ST_L4;
                end
            end
            ST_L4: begin
                mem_addr        = 18'(LAYOUT_BYTES) - 18'd4;
                mem_we          = 1'b1;
                mem_wdata       = hdr(18'd0, 1'b1, 1'b1);
                heap_top_next   = 17'(LAYOUT_BYTES);
                heap_ready_next = 1'b1;
                ext_next        = 18'(INIT_CHUNK);
                ret_grow_next   = ST_A0;
                st_next         = ST_G0;
            end
            // Allocate: adjust size, then first fit from its class upward.
            ST_A0: begin
                if (rsize_reg == 16'd0) begin
                    res_status_next = STATUS_IGNORED;
                    res_off_next    = '0;
                    st_next         = ST_DONE;
                end else begin
                    asize_next = (rsize_reg <= 16'd12) ? 18'(MIN_BLOCK) :
                                 (({2'b0, rsize_reg} + 18'd11) & ~18'd7);
                    st_next    = ST_A1;
                end
            end
            ST_A1: begin
                cls_next    = size_class(32'(asize_reg));
                budget_next = BW'(BUDGET_INIT);
                st_next     = ST_FROOT;
            end
            ST_FROOT: begin
                if (cls_reg == 5'(NUM_CLASSES)) begin
                    st_next = ST_NOFIT;
                end else begin
                    mem_addr = root_of(cls_reg);
                    st_next  = ST_FLDP;
                end
            end
            ST_FLDP: begin
                p_next  = rdata[17:0];
                st_next = ST_FCHK;
            end
            ST_FCHK: begin
                if (p_reg == '0 || budget_reg == '0) begin
                    cls_next = cls_reg + 5'd1;
                    st_next  = ST_FROOT;
                end else begin
                    budget_next = budget_reg - BW'(1);
                    mem_addr    = p_reg - 18'd4;
                    st_next     = ST_FHD;
                end
            end
            ST_FHD: begin
                if ({14'b0, asize_reg} <= rd_size32) begin
                    bp_next = p_reg;
                    st_next = ST_PL0;
                end else begin
                    mem_addr = p_reg + 18'd4;
                    st_next  = ST_FLDP;
                end
            end
            ST_NOFIT: begin
                ext_next      = (asize_reg > {1'b0, chunk_reg}) ? asize_reg : {1'b0, chunk_reg};
                ret_grow_next = ST_GROWN;
                st_next       = ST_G0;
            end
            ST_GROWN: begin
                if (grow_ok_reg) begin
                    st_next = ST_PL0;
                end else begin
                    res_status_next = STATUS_NO_MEM;
                    res_off_next    = '0;
                    st_next         = ST_DONE;
                end
            end
            // Heap growth: new free block at the old top, new epilogue, coalesce, push.
            ST_G0: begin
                if (grow_fits) begin
                    grow_ok_next  = 1'b1;
                    csize_next    = grow_sz[17:0];
                    bp_next       = {1'b0, heap_top_reg};
                    heap_top_next = heap_top_reg + grow_sz[16:0];
                    mem_addr      = {1'b0, heap_top_reg} - 18'd4;
                    st_next       = ST_G1;
                end else begin
                    grow_ok_next = 1'b0;
                    st_next      = ret_grow_reg;
                end
            end
            ST_G1: begin
                pa_next   = rdata[1];
                mem_addr  = bp_reg - 18'd4;
                mem_we    = 1'b1;
                mem_wdata = hdr(csize_reg, rdata[1], 1'b0);
                st_next   = ST_G2;
            end
            ST_G2: begin
                mem_addr  = bp_reg + csize_reg - 18'd8;
                mem_we    = 1'b1;
                mem_wdata = hdr(csize_reg, pa_reg, 1'b0);
                st_next   = ST_G3;
            end
            ST_G3: begin
                mem_addr       = bp_reg + csize_reg - 18'd4;
                mem_we         = 1'b1;
                mem_wdata      = hdr(18'd0, 1'b0, 1'b1);
                ret_merge_next = ST_G4;
                st_next        = ST_M0;
            end
            ST_G4: begin
                arg_next      = bp_reg;
                ret_leaf_next = ST_G5;
                st_next       = ST_P0;
            end
            ST_G5: begin
                st_next = ret_grow_reg;
            end
            // Coalesce the free block at bp with its free neighbours.
            ST_M0: begin
                mem_addr = bp_reg - 18'd4;
                st_next  = ST_M1;
            end
            ST_M1: begin
                pfree_next = !rdata[1];
                size_next  = rd_size;
                nb_next    = bp_reg + rd_size;
                mem_addr   = bp_reg + rd_size - 18'd4;
                st_next    = ST_M2;
            end
            ST_M2: begin
                nsize_next = rd_size;
                nfree_next = !rdata[0];
                if (pfree_reg) begin
                    mem_addr = bp_reg - 18'd8;
                    st_next  = ST_MP1;
                end else if (!rdata[0]) begin
                    arg_next      = nb_reg;
                    ret_leaf_next = ST_MW0;
                    st_next       = ST_R0;
                end else begin
                    st_next = ST_MW0;
                end
            end
            ST_MP1: begin
                pb_next       = bp_reg - rd_size;
                arg_next      = bp_reg - rd_size;
                ret_leaf_next = ST_MP2;
                st_next       = ST_R0;
            end
            ST_MP2: begin
                mem_addr = pb_reg - 18'd4;
                st_next  = ST_MP3;
            end
            ST_MP3: begin
                psize_next = rd_size;
                pa_next    = rdata[1];
                if (nfree_reg) begin
                    arg_next      = nb_reg;
                    ret_leaf_next = ST_MW0;
                    st_next       = ST_R0;
                end else begin
                    st_next = ST_MW0;
                end
            end
            ST_MW0: begin
                size_next = size_reg + (pfree_reg ? psize_reg : '0) +
                            (nfree_reg ? nsize_reg : '0);
                if (pfree_reg) begin
                    bp_next = pb_reg;
                end else begin
                    pa_next = 1'b1;
                end
                st_next = ST_MW1;
            end
            ST_MW1: begin
                mem_addr  = bp_reg - 18'd4;
                mem_we    = 1'b1;
                mem_wdata = hdr(size_reg, pa_reg, 1'b0);
                st_next   = ST_MW2;
            end
            ST_MW2: begin
                mem_addr  = bp_reg + size_reg - 18'd8;
                mem_we    = 1'b1;
                mem_wdata = hdr(size_reg, pa_reg, 1'b0);
                st_next   = ST_MF0;
            end
            ST_MF0: begin
                mem_addr = bp_reg + size_reg - 18'd4;
                st_next  = ST_MF1;
            end
            ST_MF1: begin
                mem_addr  = bp_reg + size_reg - 18'd4;
                mem_we    = 1'b1;
                mem_wdata = rdata & ~32'h2;
                st_next   = ret_merge_reg;
            end
            // Unlink the block at arg from its class list.
            ST_R0: begin
                mem_addr = arg_reg - 18'd4;
                st_next  = ST_R1;
            end
            ST_R1: begin
                root_next = root_of(size_class(rd_size32));
                mem_addr  = arg_reg;
                st_next   = ST_R2;
            end
            ST_R2: begin
                lp_next  = rdata[17:0];
                mem_addr = arg_reg + 18'd4;
                st_next  = ST_R3;
            end
            ST_R3: begin
                ls_next   = rdata[17:0];
                mem_addr  = (lp_reg == '0) ? root_reg : lp_reg + 18'd4;
                mem_we    = 1'b1;
                mem_wdata = {14'b0, rdata[17:0]};
                st_next   = ST_R4;
            end
            ST_R4: begin
                mem_addr  = ls_reg;
                mem_we    = (ls_reg != '0);
                mem_wdata = {14'b0, lp_reg};
                st_next   = ret_leaf_reg;
            end
            // Push the block at arg onto the head of its class list.
            ST_P0: begin
                mem_addr = arg_reg - 18'd4;
                st_next  = ST_P1;
            end
            ST_P1: begin
                root_next = root_of(size_class(rd_size32));
                mem_addr  = root_of(size_class(rd_size32));
                st_next   = ST_P2;
            end
            ST_P2: begin
                ls_next   = rdata[17:0];
                mem_addr  = root_reg;
                mem_we    = 1'b1;
                mem_wdata = {14'b0, arg_reg};
                st_next   = ST_P3;
            end
            ST_P3: begin
                mem_addr = arg_reg;
                mem_we   = 1'b1;
                st_next  = ST_P4;
            end
            ST_P4: begin
                mem_addr  = arg_reg + 18'd4;
                mem_we    = 1'b1;
                mem_wdata = {14'b0, ls_reg};
                st_next   = ST_P5;
            end
            ST_P5: begin
                mem_addr  = ls_reg;
                mem_we    = (ls_reg != '0);
                mem_wdata = {14'b0, arg_reg};
                st_next   = ret_leaf_reg;
            end
            // Place the allocation in the block at bp, splitting off a remainder that can form a block.
            ST_PL0: begin
                mem_addr = bp_reg - 18'd4;
                st_next  = ST_PL1;
            end
            ST_PL1: begin
                csize_next    = rd_size;
                arg_next      = bp_reg;
                ret_leaf_next = ST_PL2;
                st_next       = ST_R0;
            end
            ST_PL2: begin
                mem_addr = bp_reg - 18'd4;
                st_next  = ST_PL3;
            end
            ST_PL3: begin
                mem_addr = bp_reg - 18'd4;
                mem_we   = 1'b1;
                if ({1'b0, csize_reg} >= {1'b0, asize_reg} + 19'(MIN_BLOCK)) begin
                    mem_wdata = hdr(asize_reg, rdata[1], 1'b1);
                    arg_next  = bp_reg + asize_reg;
                    rem_next  = csize_reg - asize_reg;
                    st_next   = ST_PS1;
                end else begin
                    mem_wdata = hdr(csize_reg, rdata[1], 1'b1);
                    st_next   = ST_PN1;
                end
            end
            ST_PS1: begin
                mem_addr  = arg_reg - 18'd4;
                mem_we    = 1'b1;
                mem_wdata = hdr(rem_reg, 1'b1, 1'b0);
                st_next   = ST_PS2;
            end
            ST_PS2: begin
                mem_addr  = arg_reg + rem_reg - 18'd8;
                mem_we    = 1'b1;
                mem_wdata = hdr(rem_reg, 1'b1, 1'b0);
                st_next   = ST_PS3;
            end
            ST_PS3: begin
                mem_addr = arg_reg + rem_reg - 18'd4;
                st_next  = ST_PS4;
            end
            ST_PS4: begin
                mem_addr      = arg_reg + rem_reg - 18'd4;
                mem_we        = 1'b1;
                mem_wdata     = rdata & ~32'h2;
                ret_leaf_next = ST_PDONE;
                st_next       = ST_P0;
            end
            ST_PN1: begin
                mem_addr = bp_reg + csize_reg - 18'd4;
                st_next  = ST_PN2;
            end
            ST_PN2: begin
                mem_addr  = bp_reg + csize_reg - 18'd4;
                mem_we    = 1'b1;
                mem_wdata = rdata | 32'h2;
                st_next   = ST_PDONE;
            end
            ST_PDONE: begin
                res_status_next = STATUS_DONE;
                res_off_next    = bp_reg[15:0];
                st_next         = ST_DONE;
            end
            // Free: validate the header, mark the block free, coalesce and push.
            ST_F0: begin
                mem_addr = bp_reg - 18'd4;
                st_next  = ST_F1;
            end
            ST_F1: begin
                if (rdata[0] && rd_size32 >= 32'(MIN_BLOCK) &&
                    rd_size32 <= {14'b0, room}) begin
                    pa_next   = rdata[1];
                    size_next = rd_size;
                    mem_addr  = bp_reg - 18'd4;
                    mem_we    = 1'b1;
                    mem_wdata = hdr(rd_size, rdata[1], 1'b0);
                    st_next   = ST_F2;
                end else begin
                    res_status_next = STATUS_IGNORED;
                    res_off_next    = '0;
                    st_next         = ST_DONE;
                end
            end
            ST_F2: begin
                mem_addr       = bp_reg + size_reg - 18'd8;
                mem_we         = 1'b1;
                mem_wdata      = hdr(size_reg, pa_reg, 1'b0);
                ret_merge_next = ST_F3;
                st_next        = ST_M0;
            end
            ST_F3: begin
                arg_next      = bp_reg;
                ret_leaf_next = ST_F4;
                st_next       = ST_P0;
            end
            ST_F4: begin
                res_status_next = STATUS_DONE;
                res_off_next    = '0;
                st_next         = ST_DONE;
            end
            // Hand the result to the output register once it is free or being emptied.
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_off_next    = res_off_reg;
                    st_next         = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            heap_top_reg   <= '0;
            heap_ready_reg <= 1'b0;
            chunk_reg      <= 17'(CHUNK_RESET);
            out_valid_reg  <= 1'b0;
        end else begin
            st_reg         <= st_next;
            heap_top_reg   <= heap_top_next;
            heap_ready_reg <= heap_ready_next;
            chunk_reg      <= chunk_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_leaf_reg   <= ret_leaf_next;
        ret_merge_reg  <= ret_merge_next;
        ret_grow_reg   <= ret_grow_next;
        rsize_reg      <= rsize_next;
        bp_reg         <= bp_next;
        asize_reg      <= asize_next;
        size_reg       <= size_next;
        nsize_reg      <= nsize_next;
        psize_reg      <= psize_next;
        pb_reg         <= pb_next;
        nb_reg         <= nb_next;
        pa_reg         <= pa_next;
        pfree_reg      <= pfree_next;
        nfree_reg      <= nfree_next;
        arg_reg        <= arg_next;
        root_reg       <= root_next;
        lp_reg         <= lp_next;
        ls_reg         <= ls_next;
        p_reg          <= p_next;
        cls_reg        <= cls_next;
        budget_reg     <= budget_next;
        ext_reg        <= ext_next;
        grow_ok_reg    <= grow_ok_next;
        csize_reg      <= csize_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        out_status_reg <= out_status_next;
        out_off_reg    <= out_off_next;
    end

`ifndef ASSERT_OFF
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {2'b0, heap_top_reg} <= 19'(HEAP_BYTES))
        else $error("heap top beyond heap memory");

    a_top_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_top_reg[2:0] == 3'b000)
        else $error("heap top not double-word aligned");

    a_ready_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_ready_reg |=> heap_ready_reg)
        else $error("heap layout flag cleared");

    a_result_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == STATUS_DONE && out_off_reg != 16'd0) |->
        (out_off_reg[2:0] == 3'b000 && out_off_reg >= 16'(LAYOUT_BYTES)))
        else $error("allocated offset misaligned or inside the layout area");
`endif

endmodule
